// File: sv/smadd_pkg.sv
package smadd_pkg;

	// store geometry
	localparam int DEPTH   = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = IDX_W + 1;
	localparam int MAX_DIM = 256;
	localparam int DIM_W   = 9;
	localparam int COORD_W = 8;
	localparam int VAL_W   = 16;
	localparam int SUM_W   = VAL_W + 1;
	localparam int TRIP_W  = 2 * COORD_W + VAL_W;
	localparam int KEY_W   = 2 * COORD_W;

	// input function codes
	typedef enum logic [1:0] {
		FUNC_LOAD_A = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_MERGE  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_RESULT   = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_EMPTY    = 2'd2
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_A_ROWS    = 2'd0,
		REG_A_COLUMNS = 2'd1,
		REG_B_ROWS    = 2'd2,
		REG_B_COLUMNS = 2'd3
	} reg_idx_t;

	// controller states
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_MERGE = 1'b1
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    load_a;
		logic    load_b;
		logic    start;
		logic    step;
		logic    emit_special;
		status_t special_status;
		logic    finish;
	} smadd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic dims_match;
		logic both_empty;
		logic out_free;
		logic last_step;
	} smadd_stat_t;

endpackage

// File: sv/smadd_ctrl.sv
module smadd_ctrl
	import smadd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  smadd_stat_t stat,
	output smadd_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.special_status = STAT_RESULT;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				// a merge may answer at once, so hold input while the output is full
				in_stall = !stat.out_free;
				if (in_valid && !in_stall) begin
					case (func_t'(func))
						FUNC_LOAD_A: cmd.load_a = 1'b1;
						FUNC_LOAD_B: cmd.load_b = 1'b1;
						FUNC_MERGE: begin
							if (!stat.dims_match) begin
								cmd.emit_special   = 1'b1;
								cmd.special_status = STAT_MISMATCH;
								cmd.finish         = 1'b1;
							end else if (stat.both_empty) begin
								cmd.emit_special   = 1'b1;
								cmd.special_status = STAT_EMPTY;
								cmd.finish         = 1'b1;
							end else begin
								cmd.start = 1'b1;
								state_d   = ST_MERGE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MERGE: begin
				// one result triplet per free output slot
				if (stat.out_free) begin
					cmd.step = 1'b1;
					if (stat.last_step) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: sv/smadd_dpath.sv
module smadd_dpath
	import smadd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,
	input  logic [COORD_W-1:0]       row_index,
	input  logic [COORD_W-1:0]       column_index,
	input  logic signed [VAL_W-1:0]  entry_value,
	input  smadd_cmd_t               cmd,
	output smadd_stat_t              stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [COORD_W-1:0]       out_row,
	output logic [COORD_W-1:0]       out_column,
	output logic signed [SUM_W-1:0]  out_value,
	output logic                     last
);

	logic [DIM_W-1:0] a_rows_q, a_columns_q, b_rows_q, b_columns_q;
	logic [TRIP_W-1:0] a_store [DEPTH];
	logic [TRIP_W-1:0] b_store [DEPTH];
	logic [CNT_W-1:0] a_count_q, b_count_q;
	logic [CNT_W-1:0] i_q, j_q, i_d, j_d;
	logic [IDX_W-1:0] a_addr, b_addr;
	logic [TRIP_W-1:0] ta_q, tb_q;

	logic [TRIP_W-1:0] ta, tb, trip_in;
	logic [KEY_W-1:0]  ka, kb;
	logic              a_left, b_left, take_a, take_b, take_both;
	logic signed [SUM_W-1:0] va, vb, res_val;
	logic [COORD_W-1:0] res_row, res_col;

	logic                    out_valid_q;
	status_t                 status_q;
	logic [COORD_W-1:0]      out_row_q, out_column_q;
	logic signed [SUM_W-1:0] out_value_q;
	logic                    last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_W'(MAX_DIM);
			a_columns_q <= DIM_W'(MAX_DIM);
			b_rows_q    <= DIM_W'(MAX_DIM);
			b_columns_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_A_ROWS:    a_rows_q    <= cfg_data;
				REG_A_COLUMNS: a_columns_q <= cfg_data;
				REG_B_ROWS:    b_rows_q    <= cfg_data;
				REG_B_COLUMNS: b_columns_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign trip_in = {row_index, column_index, entry_value};

	// next read address: the entry the pointers will hold after this edge
	always_comb begin
		if (cmd.start) begin
			a_addr = '0;
			b_addr = '0;
		end else if (cmd.step) begin
			a_addr = i_d[IDX_W-1:0];
			b_addr = j_d[IDX_W-1:0];
		end else begin
			a_addr = i_q[IDX_W-1:0];
			b_addr = j_q[IDX_W-1:0];
		end
	end

	// triplet stores, appended at the fill count and read one step ahead
	always_ff @(posedge clk) begin
		if (cmd.load_a && (a_count_q < CNT_W'(DEPTH))) begin
			a_store[a_count_q[IDX_W-1:0]] <= trip_in;
		end
		if (cmd.load_b && (b_count_q < CNT_W'(DEPTH))) begin
			b_store[b_count_q[IDX_W-1:0]] <= trip_in;
		end
		ta_q <= a_store[a_addr];
		tb_q <= b_store[b_addr];
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else if (cmd.finish) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else begin
			if (cmd.load_a && (a_count_q < CNT_W'(DEPTH))) begin
				a_count_q <= a_count_q + 1'b1;
			end
			if (cmd.load_b && (b_count_q < CNT_W'(DEPTH))) begin
				b_count_q <= b_count_q + 1'b1;
			end
		end
	end

	// merge compare and select
	always_comb begin
		ta        = ta_q;
		tb        = tb_q;
		ka        = ta[TRIP_W-1 -: KEY_W];
		kb        = tb[TRIP_W-1 -: KEY_W];
		va        = SUM_W'(signed'(ta[VAL_W-1:0]));
		vb        = SUM_W'(signed'(tb[VAL_W-1:0]));
		a_left    = i_q < a_count_q;
		b_left    = j_q < b_count_q;
		take_both = a_left && b_left && (ka == kb);
		take_a    = a_left && (!b_left || (ka < kb));
		take_b    = b_left && (!a_left || (ka > kb));
		if (take_b) begin
			res_row = kb[KEY_W-1 -: COORD_W];
			res_col = kb[COORD_W-1:0];
			res_val = vb;
		end else begin
			res_row = ka[KEY_W-1 -: COORD_W];
			res_col = ka[COORD_W-1:0];
			res_val = take_both ? (va + vb) : va;
		end
		i_d = i_q + CNT_W'(take_a || take_both);
		j_d = j_q + CNT_W'(take_b || take_both);
	end

	// merge read pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.step) begin
			i_q <= i_d;
			j_q <= j_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step || cmd.emit_special) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_special) begin
			status_q     <= cmd.special_status;
			out_row_q    <= '0;
			out_column_q <= '0;
			out_value_q  <= '0;
			last_q       <= 1'b1;
		end else if (cmd.step) begin
			status_q     <= STAT_RESULT;
			out_row_q    <= res_row;
			out_column_q <= res_col;
			out_value_q  <= res_val;
			last_q       <= stat.last_step;
		end
	end

	assign stat.dims_match = (a_rows_q == b_rows_q) && (a_columns_q == b_columns_q);
	assign stat.both_empty = (a_count_q == '0) && (b_count_q == '0);
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.last_step  = (i_d == a_count_q) && (j_d == b_count_q);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_row    = out_row_q;
	assign out_column = out_column_q;
	assign out_value  = out_value_q;
	assign last       = last_q;

endmodule

// File: sv/sparse_triplet_matrix_add.sv
// Sparse matrix adder over row-major triplet lists. A load transaction (func 0 or 1)
// appends one (row, column, value) triplet to list A or B; loads into a full list
// (32 triplets) are dropped. A merge transaction (func 2) compares the dimension
// registers, then walks both lists with one compare-and-select step per cycle while
// the output is not stalled, so a merge of na and nb triplets with p matching pairs
// gives na + nb - p result triplets, one per step, with last on the final result; a
// mismatch or two empty lists give a single status result in the cycle after the
// merge is taken. Input is stalled for the whole merge and whenever the output
// register holds a result that is not taken. Every merge empties both lists. Lists
// must be loaded in row-major order for a meaningful sum.
module sparse_triplet_matrix_add
	import smadd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [COORD_W-1:0]       row_index,
	input  logic [COORD_W-1:0]       column_index,
	input  logic signed [VAL_W-1:0]  entry_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [COORD_W-1:0]       out_row,
	output logic [COORD_W-1:0]       out_column,
	output logic signed [SUM_W-1:0]  out_value,
	output logic                     last
);

	smadd_cmd_t  cmd;
	smadd_stat_t stat;

	// sequencer
	smadd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores, merge step and output register
	smadd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_row      (out_row),
		.out_column   (out_column),
		.out_value    (out_value),
		.last         (last)
	);

endmodule

// File: sv/smadd_checker.sv
module smadd_checker
	import smadd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               status,
	input logic [COORD_W-1:0]       out_row,
	input logic [COORD_W-1:0]       out_column,
	input logic signed [SUM_W-1:0]  out_value,
	input logic                     last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_row)
			&& $stable(out_column) && $stable(out_value) && $stable(last))
		else $error("stalled result changed");

	// status results end a merge
	a_special_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_RESULT) |-> last)
		else $error("status result without last");

	// status results carry zero payload
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_RESULT) |->
			(out_row == '0) && (out_column == '0) && (out_value == '0))
		else $error("status result with nonzero payload");

	// input held off while a merge is still in progress
	a_merge_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken during merge");

endmodule

bind sparse_triplet_matrix_add smadd_checker u_smadd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.out_row    (out_row),
	.out_column (out_column),
	.out_value  (out_value),
	.last       (last)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import smadd_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int CHUNK_ITEMS  = 18;

	// one stored triplet and one expected result
	typedef struct {
		logic [COORD_W-1:0]      row;
		logic [COORD_W-1:0]      col;
		logic signed [VAL_W-1:0] value;
	} triplet_t;

	typedef struct {
		status_t                 status;
		logic [COORD_W-1:0]      row;
		logic [COORD_W-1:0]      col;
		logic signed [SUM_W-1:0] value;
		logic                    last;
	} sum_entry_t;

	// predicts the merged triplet stream and checks it against the block
	class sum_board;
		triplet_t   a_list[$];
		triplet_t   b_list[$];
		logic [DIM_W-1:0] dims[4];
		sum_entry_t sums_due[$];
		int         mismatches;

		function new();
			for (int k = 0; k < 4; k++) dims[k] = DIM_W'(MAX_DIM);
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DIM_W-1:0] v);
			dims[idx] = v;
		endfunction

		function int pending();
			return sums_due.size();
		endfunction

		function void push_sum(status_t st, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
				logic signed [SUM_W-1:0] v);
			sum_entry_t e;
			e.status = st;
			e.row    = r;
			e.col    = c;
			e.value  = v;
			e.last   = 1'b0;
			sums_due.push_back(e);
		endfunction

		// row-major merge of both lists, equal coordinates are summed
		function void predict_merge();
			int i, j;
			logic [2*COORD_W-1:0] ka, kb;
			logic signed [SUM_W-1:0] s;
			i = 0;
			j = 0;
			if (dims[REG_A_ROWS] != dims[REG_B_ROWS] ||
					dims[REG_A_COLUMNS] != dims[REG_B_COLUMNS]) begin
				push_sum(STAT_MISMATCH, '0, '0, '0);
			end else if (a_list.size() == 0 && b_list.size() == 0) begin
				push_sum(STAT_EMPTY, '0, '0, '0);
			end else begin
				while (i < a_list.size() && j < b_list.size()) begin
					ka = {a_list[i].row, a_list[i].col};
					kb = {b_list[j].row, b_list[j].col};
					if (ka < kb) begin
						push_sum(STAT_RESULT, a_list[i].row, a_list[i].col, a_list[i].value);
						i++;
					end else if (ka > kb) begin
						push_sum(STAT_RESULT, b_list[j].row, b_list[j].col, b_list[j].value);
						j++;
					end else begin
						s = a_list[i].value;
						s = s + b_list[j].value;
						push_sum(STAT_RESULT, a_list[i].row, a_list[i].col, s);
						i++;
						j++;
					end
				end
				for (; i < a_list.size(); i++)
					push_sum(STAT_RESULT, a_list[i].row, a_list[i].col, a_list[i].value);
				for (; j < b_list.size(); j++)
					push_sum(STAT_RESULT, b_list[j].row, b_list[j].col, b_list[j].value);
			end
			sums_due[sums_due.size()-1].last = 1'b1;
			a_list.delete();
			b_list.delete();
		endfunction

		// returns 1 when the transaction changed the state
		function bit note_input(func_t f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
				logic [VAL_W-1:0] v);
			triplet_t t;
			t.row   = r;
			t.col   = c;
			t.value = v;
			case (f)
				FUNC_LOAD_A: begin
					if (a_list.size() < DEPTH) begin
						a_list.push_back(t);
						return 1'b1;
					end
				end
				FUNC_LOAD_B: begin
					if (b_list.size() < DEPTH) begin
						b_list.push_back(t);
						return 1'b1;
					end
				end
				FUNC_MERGE: begin
					predict_merge();
					return 1'b1;
				end
				default: ;
			endcase
			return 1'b0;
		endfunction

		function void check_result(logic [1:0] st, logic [COORD_W-1:0] r,
				logic [COORD_W-1:0] c, logic signed [SUM_W-1:0] v, logic l);
			sum_entry_t e;
			if (sums_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result status %0d row %0d col %0d value %0d last %0d",
						$realtime, st, r, c, v, l);
				return;
			end
			e = sums_due.pop_front();
			if (st !== e.status || r !== e.row || c !== e.col || v !== e.value ||
					l !== e.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected status %0d row %0d col %0d value %0d last %0d",
						e.status, e.row, e.col, e.value, e.last);
					$display("  actual   status %0d row %0d col %0d value %0d last %0d",
						st, r, c, v, l);
				end
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [DIM_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              func;
	logic [COORD_W-1:0]      row_index;
	logic [COORD_W-1:0]      column_index;
	logic signed [VAL_W-1:0] entry_value;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              status;
	logic [COORD_W-1:0]      out_row;
	logic [COORD_W-1:0]      out_column;
	logic signed [SUM_W-1:0] out_value;
	logic                    last;

	sum_board board;
	int       items_done = 0;
	int       idle_pct   = 0;
	int       stall_pct  = 0;
	int       hold_left  = 0;
	int       cycle_count;

	sparse_triplet_matrix_add DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.row_index    (row_index),
		.column_index (column_index),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_row      (out_row),
		.out_column   (out_column),
		.out_value    (out_value),
		.last         (last)
	);

	always #5 clk = ~clk;

	// receiver: random stall, or a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_result(status, out_row, out_column, out_value, last);
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// offer one input transaction and wait until it is taken
	task automatic send_item(func_t f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic [VAL_W-1:0] v);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		row_index    <= r;
		column_index <= c;
		entry_value  <= v;
		do @(posedge clk); while (in_stall);
		if (board.note_input(f, r, c, v)) items_done++;
	endtask

	// drop valid and wait until every expected result has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dims(int ar, int ac, int br, int bc);
		int vals[4];
		reg_idx_t idx;
		vals = '{ar, ac, br, bc};
		settle();
		for (int k = 0; k < 4; k++) begin
			idx = reg_idx_t'(k);
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= DIM_W'(vals[k]);
			board.write_reg(idx, DIM_W'(vals[k]));
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// packed {row, column} key, optionally from a narrow band of rows
	function automatic int pick_key(int row_base, bit narrow);
		int row;
		row = narrow ? (row_base + $urandom_range(0, 2)) % 256 : $urandom_range(0, 255);
		return row * 256 + $urandom_range(0, 255);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) return 16'h8000;
		if (sel < 16) return 16'h7fff;
		if (sel < 20) return 16'hffff;
		return VAL_W'($urandom);
	endfunction

	// sorted and deduplicated, or shuffled for an out-of-order list
	function automatic void tidy_keys(ref int keys[$], input bit scramble);
		int tidy[$];
		if (scramble) begin
			keys.shuffle();
			return;
		end
		keys.sort();
		foreach (keys[k])
			if (k == 0 || keys[k] != keys[k-1]) tidy.push_back(keys[k]);
		keys = tidy;
	endfunction

	// load two lists in random interleave, then merge
	task automatic run_batch(int na, int nb, int share_pct, bit scramble);
		int a_keys[$], b_keys[$];
		logic [VAL_W-1:0] a_vals[int];
		logic [VAL_W-1:0] a_data[$], b_data[$];
		int row_base, i, j;
		bit narrow;
		row_base = $urandom_range(0, 255);
		narrow   = 1'($urandom_range(0, 1));
		repeat (na) a_keys.push_back(pick_key(row_base, narrow));
		tidy_keys(a_keys, scramble);
		foreach (a_keys[k]) begin
			a_data.push_back(pick_value());
			a_vals[a_keys[k]] = a_data[k];
		end
		repeat (nb) begin
			if (a_keys.size() > 0 && $urandom_range(0, 99) < share_pct)
				b_keys.push_back(a_keys[$urandom_range(0, a_keys.size() - 1)]);
			else
				b_keys.push_back(pick_key(row_base, narrow));
		end
		tidy_keys(b_keys, scramble);
		// shared coordinates sometimes cancel to a zero sum
		foreach (b_keys[k]) begin
			if (a_vals.exists(b_keys[k]) && $urandom_range(0, 3) == 0)
				b_data.push_back(-a_vals[b_keys[k]]);
			else
				b_data.push_back(pick_value());
		end
		i = 0;
		j = 0;
		while (i < a_keys.size() || j < b_keys.size()) begin
			if ($urandom_range(0, 99) < 3)
				send_item(FUNC_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_value());
			if (j >= b_keys.size() || (i < a_keys.size() && $urandom_range(0, 1))) begin
				send_item(FUNC_LOAD_A, 8'(a_keys[i] >> 8), 8'(a_keys[i]), a_data[i]);
				i++;
			end else begin
				send_item(FUNC_LOAD_B, 8'(b_keys[j] >> 8), 8'(b_keys[j]), b_data[j]);
				j++;
			end
		end
		send_item(FUNC_MERGE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			pick_value());
	endtask

	initial begin
		int sel, na, nb, r, c, target;
		board        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_A_ROWS;
		cfg_data     = '0;
		in_valid     = 1'b0;
		func         = FUNC_NONE;
		row_index    = '0;
		column_index = '0;
		entry_value  = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty merge, extreme sums, zero sum, one-sided tails
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);
		send_item(FUNC_LOAD_A, 8'd0, 8'd0, 16'h8000);
		send_item(FUNC_LOAD_B, 8'd0, 8'd0, 16'h7fff);
		send_item(FUNC_LOAD_A, 8'd0, 8'd5, 16'h8000);
		send_item(FUNC_LOAD_B, 8'd0, 8'd5, 16'h8000);
		send_item(FUNC_LOAD_A, 8'd7, 8'd200, 16'd100);
		send_item(FUNC_LOAD_B, 8'd7, 8'd200, -16'sd100);
		send_item(FUNC_LOAD_B, 8'd128, 8'd3, 16'd1);
		send_item(FUNC_LOAD_A, 8'd255, 8'd255, 16'h7fff);
		send_item(FUNC_LOAD_B, 8'd255, 8'd255, 16'h7fff);
		send_item(FUNC_NONE, 8'hff, 8'hff, 16'hffff);
		send_item(FUNC_MERGE, 8'hff, 8'hff, 16'hffff);
		send_item(FUNC_LOAD_A, 8'd3, 8'd3, 16'd5);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);
		send_item(FUNC_LOAD_B, 8'd9, 8'd9, -16'sd7);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);

		// directed: dimension mismatch, then a matching 1 x 1 shape
		write_dims(1, 1, 1, 256);
		send_item(FUNC_LOAD_A, 8'd0, 8'd0, 16'd1);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);
		write_dims(1, 1, 1, 1);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);
		send_item(FUNC_LOAD_A, 8'd1, 8'd2, 16'd3);
		send_item(FUNC_LOAD_B, 8'd0, 8'd9, 16'd4);
		send_item(FUNC_MERGE, 8'd0, 8'd0, 16'h0000);

		// random phases, each with its own idling profile
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			for (int chunk = 0; chunk < 3; chunk++) begin
				if (chunk == 0) begin
					case (ph)
						0: write_dims(256, 256, 256, 256);
						1: write_dims(1, 1, 1, 1);
						2: write_dims(255, 255, 255, 255);
						default: write_dims(256, 1, 256, 1);
					endcase
				end else begin
					r   = $urandom_range(1, 256);
					c   = $urandom_range(1, 256);
					sel = $urandom_range(0, 3);
					if (sel == 0) write_dims(r, c, r % 256 + 1, c);
					else if (sel == 1) write_dims(r, c, r, c % 256 + 1);
					else write_dims(r, c, r, c);
				end
				// long receiver hold-off so the block backs up into its input
				if (ph == 0 && chunk == 0) begin
					hold_left = 300;
					run_batch(12, 12, 50, 1'b0);
				end
				target = items_done + CHUNK_ITEMS;
				while (items_done < target) begin
					sel = $urandom_range(0, 99);
					if (sel < 70) begin
						na = $urandom_range(0, 6);
						nb = $urandom_range(0, 6);
					end else if (sel < 90) begin
						na = $urandom_range(7, 20);
						nb = $urandom_range(7, 20);
					end else if (sel < 96) begin
						na = DEPTH;
						nb = DEPTH;
					end else begin
						na = $urandom_range(DEPTH + 1, DEPTH + 4);
						nb = $urandom_range(0, DEPTH + 4);
					end
					run_batch(na, nb, $urandom_range(0, 80), $urandom_range(0, 99) < 5);
				end
			end
		end

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
